>>> rtl/core/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg: shared types and constants for the signed integer to decimal text unit
// Holds character codes, BCD sizing, the emitter state encoding and the
// conversion result word passed from the converter to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package sid_pkg;

	// Input value width and decimal sizing (2^32 needs ten digits)
	localparam int unsigned NUM_W    = 32;
	localparam int unsigned DIG_N    = 10;
	localparam int unsigned BCD_W    = DIG_N * 4;
	localparam int unsigned BITCNT_W = $clog2(NUM_W);
	localparam int unsigned DIGCNT_W = $clog2(DIG_N);
	localparam int unsigned CHAR_W   = 7;

	localparam logic [BITCNT_W-1:0] BIT_LAST = BITCNT_W'(NUM_W - 1);
	localparam logic [DIGCNT_W-1:0] DIG_LAST = DIGCNT_W'(DIG_N - 1);

	// Character codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;

	// Emitter sequencer states
	typedef enum logic [1:0] {
		E_IDLE,
		E_SIGN,
		E_DIGIT,
		E_CR
	} sid_emit_state_t;

	// Finished conversion word from converter to emitter
	typedef struct packed {
		logic             done;
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} sid_conv_t;

endpackage

`default_nettype wire

>>> rtl/core/sid_dabble.sv
// ----------------------------------------------------------------------------
// sid_dabble: bit-serial binary to BCD converter
// Takes the magnitude of a signed word and shifts it MSB first into a ten
// digit BCD register, adding three to any digit of five or more each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_dabble (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire logic [sid_pkg::NUM_W-1:0]    value,
	output sid_pkg::sid_conv_t                conv,
	output logic                              busy
);

	logic                            active_q;
	logic                            done_q;
	logic                            neg_q;
	logic [sid_pkg::BITCNT_W-1:0]    cnt_q;
	logic [sid_pkg::NUM_W-1:0]       bin_q;
	logic [sid_pkg::BCD_W-1:0]       bcd_q;
	logic [sid_pkg::BCD_W-1:0]       bcd_adj;
	logic [sid_pkg::NUM_W-1:0]       mag;

	// Form the magnitude in unsigned arithmetic so the most negative value survives
	assign mag = value[sid_pkg::NUM_W-1] ? (~value + sid_pkg::NUM_W'(1)) : value;

	// Add three to each digit that would overflow on the next doubling
	always_comb begin
		for (int i = 0; i < sid_pkg::DIG_N; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Control: run one bit per cycle, pulse done after the last bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + sid_pkg::BITCNT_W'(1);
				if (cnt_q == sid_pkg::BIT_LAST) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the binary word into the BCD register
	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= mag;
			bcd_q <= '0;
			neg_q <= value[sid_pkg::NUM_W-1];
		end else if (active_q) begin
			bin_q <= {bin_q[sid_pkg::NUM_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[sid_pkg::BCD_W-2:0], bin_q[sid_pkg::NUM_W-1]};
		end
	end

	assign conv.done = done_q;
	assign conv.neg  = neg_q;
	assign conv.bcd  = bcd_q;
	assign busy      = active_q | done_q;

`ifndef SYNTHESIS
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !load && cnt_q == sid_pkg::BIT_LAST) |=> done_q)
		else $error("converter missed done after last bit");
	a_done_not_active: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !active_q)
		else $error("converter done while still shifting");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sid_emit.sv
// ----------------------------------------------------------------------------
// sid_emit: decimal character emitter
// Sends an optional minus, the BCD digits MSB first without leading zeros,
// and a closing carriage return, one character per strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_emit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sid_pkg::sid_conv_t          conv,
	output logic                             strobe,
	output logic [sid_pkg::CHAR_W-1:0]       char_code,
	output logic                             last_char,
	output logic                             busy
);

	sid_pkg::sid_emit_state_t            state_q;
	sid_pkg::sid_emit_state_t            state_d;
	logic [sid_pkg::BCD_W-1:0]           dig_q;
	logic [sid_pkg::DIGCNT_W-1:0]        cnt_q;
	logic                                seen_q;
	logic                                strobe_q;
	logic                                last_q;
	logic [sid_pkg::CHAR_W-1:0]          char_q;
	logic                                emit_d;
	logic                                last_d;
	logic [sid_pkg::CHAR_W-1:0]          char_d;
	logic [3:0]                          cur_dig;

	assign cur_dig = dig_q[sid_pkg::BCD_W-1 -: 4];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sid_pkg::E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and character selection
	always_comb begin
		state_d = state_q;
		emit_d  = 1'b0;
		last_d  = 1'b0;
		char_d  = sid_pkg::CH_CR;
		case (state_q)
			sid_pkg::E_IDLE: begin
				if (conv.done) begin
					state_d = conv.neg ? sid_pkg::E_SIGN : sid_pkg::E_DIGIT;
				end
			end
			sid_pkg::E_SIGN: begin
				emit_d  = 1'b1;
				char_d  = sid_pkg::CH_MINUS;
				state_d = sid_pkg::E_DIGIT;
			end
			sid_pkg::E_DIGIT: begin
				// Drop leading zeros but always keep the units digit
				emit_d = seen_q || (cur_dig != 4'd0) || (cnt_q == sid_pkg::DIG_LAST);
				char_d = sid_pkg::CH_ZERO + {3'b000, cur_dig};
				if (cnt_q == sid_pkg::DIG_LAST) begin
					state_d = sid_pkg::E_CR;
				end
			end
			sid_pkg::E_CR: begin
				emit_d  = 1'b1;
				last_d  = 1'b1;
				char_d  = sid_pkg::CH_CR;
				state_d = sid_pkg::E_IDLE;
			end
			default: begin
				state_d = sid_pkg::E_IDLE;
			end
		endcase
	end

	// Output word register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= emit_d;
			last_q   <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		char_q <= char_d;
	end

	// Digit shift register: advance one digit per cycle in the digit phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			cnt_q  <= '0;
		end else if (state_q == sid_pkg::E_IDLE && conv.done) begin
			seen_q <= 1'b0;
			cnt_q  <= '0;
		end else if (state_q == sid_pkg::E_DIGIT) begin
			seen_q <= seen_q | (cur_dig != 4'd0);
			cnt_q  <= cnt_q + sid_pkg::DIGCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sid_pkg::E_IDLE && conv.done) begin
			dig_q <= conv.bcd;
		end else if (state_q == sid_pkg::E_DIGIT) begin
			dig_q <= {dig_q[sid_pkg::BCD_W-5:0], 4'd0};
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last_char = last_q;
	assign busy      = (state_q != sid_pkg::E_IDLE);

`ifndef SYNTHESIS
	a_last_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> (strobe_q && char_q == sid_pkg::CH_CR))
		else $error("last character is not a strobed carriage return");
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		conv.done |-> (state_q == sid_pkg::E_IDLE))
		else $error("conversion finished while emitter busy");
`endif

endmodule

`default_nettype wire

>>> rtl/core/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed 32-bit integer to decimal ASCII
// A word is taken on start while busy is low. The bit-serial converter shifts
// in every bit of the magnitude and hands the BCD result to the emitter; digits
// then follow one per cycle, a leading zero digit passing without a strobe, and
// a minus sign going first. Busy falls as the carriage return strobes, so a new
// word is taken only once the previous one is fully sent. The receiver cannot
// stall. Reset (arst_n low) idles both sequencers.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [31:0]            number_in,
	output logic                               strobe,
	output logic [6:0]                         char_code,
	output logic                               last_char
);

	sid_pkg::sid_conv_t conv;
	logic               conv_busy;
	logic               emit_busy;
	logic               accept;

	// Take a new word only when both stages are idle
	assign accept = start & ~busy;
	assign busy   = conv_busy | emit_busy;

	sid_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.value  (number_in),
		.conv   (conv),
		.busy   (conv_busy)
	);

	sid_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.conv      (conv),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char),
		.busy      (emit_busy)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("unit not busy after taking a word");
`endif

endmodule

`default_nettype wire

>>> bench/signed_int_to_decimal_ascii_unit_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb: self-checking bench for the decimal text unit
// Sends signed 32-bit words through the start/busy handshake and checks every
// strobed character against a predicted text. The predicted text is a minus
// sign for negative values, the digits with no leading zeros, and a closing
// carriage return. Covers corner values and each digit count, then random words
// with idle bursts, and ends with a back-to-back stretch.
// ----------------------------------------------------------------------------

module signed_int_to_decimal_ascii_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RESET_CYCLES = 9;
	localparam int          RANDOM_WORDS = 420;
	localparam int          TAIL_WORDS   = 60;
	localparam int          DRAIN_CYCLES = 64;
	localparam int unsigned RADIX        = 10;
	localparam int          WATCHDOG_NS  = 2_000_000;

	typedef struct packed {
		logic [sid_pkg::CHAR_W-1:0] code;
		logic                       last;
	} char_word_t;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       start     = 1'b0;
	logic signed [31:0]         number_in = '0;
	logic                       busy;
	logic                       strobe;
	logic [sid_pkg::CHAR_W-1:0] char_code;
	logic                       last_char;

	// Expected characters, oldest first
	char_word_t  text_q[$];

	int unsigned words_sent  = 0;
	int unsigned neg_words   = 0;
	int unsigned chars_seen  = 0;
	int unsigned error_count = 0;
	bit          no_gaps     = 1'b0;

	signed_int_to_decimal_ascii_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.number_in (number_in),
		.strobe    (strobe),
		.char_code (char_code),
		.last_char (last_char)
	);

	// Free-running clock, 8 ns period
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#(WATCHDOG_NS);
		$display("signed_int_to_decimal_ascii_unit_tb: errors");
		$finish;
	end

	// Append the decimal text of one word to the expected characters
	function automatic void queue_decimal_text(logic [31:0] value);
		bit [31:0]                  mag;
		logic [sid_pkg::CHAR_W-1:0] digit_buf[10];
		int                         nd;
		char_word_t                 cw;
		mag = value[31] ? (32'd0 - value) : value;
		nd  = 0;
		// peel digits least significant first
		do begin
			digit_buf[nd] = sid_pkg::CH_ZERO + sid_pkg::CHAR_W'(mag % RADIX);
			mag = mag / RADIX;
			nd++;
		end while (mag != 0);
		if (value[31]) begin
			cw.code = sid_pkg::CH_MINUS;
			cw.last = 1'b0;
			text_q.push_back(cw);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			cw.code = digit_buf[i];
			cw.last = 1'b0;
			text_q.push_back(cw);
		end
		cw.code = sid_pkg::CH_CR;
		cw.last = 1'b1;
		text_q.push_back(cw);
	endfunction

	// Random value with exactly the given number of decimal digits
	function automatic logic [31:0] value_of_digits(int k);
		longint unsigned lo;
		longint unsigned hi;
		lo = 1;
		repeat (k - 1) lo = lo * RADIX;
		hi = (k >= 10) ? 64'h7FFF_FFFF : lo * RADIX - 1;
		if (k == 1)
			lo = 0;
		return $urandom_range(32'(hi), 32'(lo));
	endfunction

	// Draw a word from a mix of full-range, small, decade and boundary values
	function automatic logic [31:0] pick_value();
		logic [31:0]     v;
		longint unsigned p;
		int              k;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = 32'(int'($urandom_range(0, 200)) - 100);
			3: begin
				k = $urandom_range(0, 9);
				p = 1;
				repeat (k) p = p * RADIX;
				v = 32'(longint'(p) + longint'($urandom_range(0, 2)) - 1);
				if ($urandom_range(0, 1))
					v = 32'd0 - v;
			end
			4: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 20)
			                            : 32'h8000_0000 + $urandom_range(0, 20);
			default: begin
				v = value_of_digits($urandom_range(1, 10));
				if ($urandom_range(0, 1))
					v = 32'd0 - v;
			end
		endcase
		return v;
	endfunction

	// Hold start low for the requested idle stretch, with noise on the data port
	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start     <= 1'b0;
			number_in <= $urandom;
		end
	endtask

	// Insert a random idle burst unless gaps are switched off
	task automatic maybe_idle();
		if (!no_gaps && $urandom_range(0, 2) == 0)
			idle_cycles($urandom_range(1, 18));
	endtask

	// Offer one word and hold it until the unit takes it
	task automatic send_word(logic [31:0] value);
		@(negedge clk);
		start     <= 1'b1;
		number_in <= value;
		do begin
			@(posedge clk);
		end while (busy);
		queue_decimal_text(value);
		words_sent++;
		if (value[31])
			neg_words++;
	endtask

	// Zero, single digits, decade steps and both ends of the range
	task automatic test_corner_values();
		logic [31:0] corner_vals[14];
		corner_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
		                32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
		                32'h7FFF_FFFE, 32'd1_000_000_000, -32'sd1_000_000_000,
		                32'd999_999_999};
		foreach (corner_vals[i]) begin
			maybe_idle();
			send_word(corner_vals[i]);
		end
	endtask

	// One word of each length from one to ten digits, negative for odd lengths
	task automatic test_digit_counts();
		logic [31:0] v;
		for (int k = 1; k <= 10; k++) begin
			v = value_of_digits(k);
			if (k[0])
				v = 32'd0 - v;
			maybe_idle();
			send_word(v);
		end
	endtask

	// Random words, switching idle bursts on and off in stretches
	task automatic test_random_words();
		for (int i = 0; i < RANDOM_WORDS - TAIL_WORDS; i++) begin
			if (i % 30 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			maybe_idle();
			send_word(pick_value());
		end
	endtask

	// Keep start high so each word follows the previous one at once
	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (TAIL_WORDS)
			send_word(pick_value());
	endtask

	// Compare each strobed character with the oldest expected one
	always @(posedge clk) begin
		char_word_t want;
		if (arst_n && strobe) begin
			chars_seen++;
			if (text_q.size() == 0) begin
				error_count++;
				$display("%0t: unexpected char: expected none, actual code %02h last %0b",
				         $time, char_code, last_char);
			end else begin
				want = text_q.pop_front();
				if (char_code !== want.code) begin
					error_count++;
					$display("%0t: char_code mismatch: expected %02h, actual %02h",
					         $time, want.code, char_code);
				end
				if (last_char !== want.last) begin
					error_count++;
					$display("%0t: last_char mismatch: expected %0b, actual %0b",
					         $time, want.last, last_char);
				end
			end
		end
	end

	// Sequence the tests, drain, and report
	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		test_corner_values();
		test_digit_counts();
		test_random_words();
		test_back_to_back();
		idle_cycles(1);
		while (text_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d words converted (%0d negative), %0d characters checked",
		         words_sent, neg_words, chars_seen);
		$display("covered zero, both range ends, every digit count, idle bursts and back-to-back");
		if (error_count == 0)
			$display("signed_int_to_decimal_ascii_unit_tb: clean");
		else
			$display("signed_int_to_decimal_ascii_unit_tb: errors");
		$finish;
	end

endmodule
